// File: rtl/kbt_pkg.sv
`default_nettype none
package kbt_pkg;

  localparam int NUM_BUCKETS = 256;
  localparam int WORD_W      = 64;
  localparam int ID_W        = 4 * WORD_W;
  localparam int ENTRY_W     = ID_W + 2 * WORD_W;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SELF     = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_BASE,
    S_FILL_WAIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_WR_NEW,
    S_ENT_WAIT,
    S_FIN
  } state_t;

  // request from the sequencer to the per-bucket fill table
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic [7:0] bkt;
  } fill_req_t;

  // position of the highest set bit, halving search
  function automatic logic [5:0] msb64(input logic [63:0] x);
    logic [63:0] v;
    logic [5:0]  p;
    v = x;
    p = '0;
    if (v[63:32] != '0) begin p[5] = 1'b1; v = v >> 32; end
    if (v[31:16] != '0) begin p[4] = 1'b1; v = v >> 16; end
    if (v[15:8]  != '0) begin p[3] = 1'b1; v = v >> 8;  end
    if (v[7:4]   != '0) begin p[2] = 1'b1; v = v >> 4;  end
    if (v[3:2]   != '0) begin p[1] = 1'b1; v = v >> 2;  end
    if (v[1])           begin p[0] = 1'b1; end
    return p;
  endfunction

endpackage
`default_nettype wire

// File: rtl/kbt_ram.sv
`default_nettype none
module kbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/kbt_fill.sv
`default_nettype none
module kbt_fill import kbt_pkg::*; #(
  parameter int FW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fill_req_t     req,
  input  wire logic [FW-1:0] wr_fill,
  output logic      [FW-1:0] rd_fill
);

  logic [NUM_BUCKETS-1:0] vld_r;
  logic                   vld_q_r;
  logic [FW-1:0]          ram_q;

  kbt_ram #(.WIDTH(FW), .DEPTH(NUM_BUCKETS)) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.bkt),
    .wr_data (wr_fill),
    .rd_en   (req.rd_en),
    .rd_addr (req.bkt),
    .rd_data (ram_q)
  );

  // a bucket never written reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.bkt] <= 1'b1;
      end
      if (req.rd_en) begin
        vld_q_r <= vld_r[req.bkt];
      end
    end
  end

  assign rd_fill = vld_q_r ? ram_q : '0;

endmodule
`default_nettype wire

// File: rtl/xor_distance_kbucket_table_core.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready  | command, peer id words, address, time, slot
// out_    | output    | out_valid / out_ready| status, bucket, fill, total, entry fields
// cfg_    | input     | cfg_valid / cfg_ready| cfg_index (0..3 local id word), cfg_data
//
// One item at a time. The distance is scanned one word per cycle.
// Read entry reads the fill, then the entry if the slot is below it. Query compares
// the stored ids slot by slot. Insert/remove shift entries one slot at a time, insert
// then writes slot 0; the single read port of the entry memory serializes the shift.
// Reset clears the fill table valid bits and total; no clearing pass.
// A result waiting on out_ready holds the sequencer in its final state.
`default_nettype none
module xor_distance_kbucket_table_core import kbt_pkg::*; #(
  parameter int BUCKET_SLOTS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [63:0] in_peer_id_w0,
  input  wire logic [63:0] in_peer_id_w1,
  input  wire logic [63:0] in_peer_id_w2,
  input  wire logic [63:0] in_peer_id_w3,
  input  wire logic [63:0] in_peer_address,
  input  wire logic [63:0] in_now_time,
  input  wire logic [7:0]  in_read_bucket,
  input  wire logic [4:0]  in_read_slot,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_bucket_number,
  output logic             out_bucket_valid,
  output logic [4:0]       out_bucket_fill,
  output logic [12:0]      out_table_total,
  output logic [63:0]      out_entry_id_w0,
  output logic [63:0]      out_entry_id_w1,
  output logic [63:0]      out_entry_id_w2,
  output logic [63:0]      out_entry_id_w3,
  output logic [63:0]      out_entry_address,
  output logic [63:0]      out_entry_last_seen
);

  localparam int NSLOT = NUM_BUCKETS * BUCKET_SLOTS;
  localparam int AW    = $clog2(NSLOT);
  localparam int FW    = $clog2(BUCKET_SLOTS + 1);
  localparam int TW    = $clog2(NSLOT + 1);
  localparam int CW    = (FW > 5) ? FW : 5;
  localparam logic [FW-1:0] SLOTS_F = FW'(BUCKET_SLOTS);
  localparam logic [AW-1:0] SLOTS_A = AW'(BUCKET_SLOTS);
  localparam logic [TW-1:0] NSLOT_T = TW'(NSLOT);

  state_t        state_r, state_nxt;
  logic [63:0]   local_id_r [4];
  cmd_t          cmd_r, cmd_nxt;
  logic [63:0]   pid_r [4];
  logic [63:0]   pid_nxt [4];
  logic [63:0]   paddr_r, paddr_nxt, ptime_r, ptime_nxt;
  logic [4:0]    rslot_r, rslot_nxt;
  logic [1:0]    w_r, w_nxt;
  logic [7:0]    bkt_r, bkt_nxt;
  logic          bvalid_r, bvalid_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [FW-1:0] fill_r, fill_nxt, s_r, s_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic          found_r, found_nxt, fpend_r, fpend_nxt;
  status_t       status_r, status_nxt;
  logic [ENTRY_W-1:0] ent_r, ent_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            ostat_r, ostat_nxt;
  logic [7:0]         obkt_r, obkt_nxt;
  logic               obv_r, obv_nxt;
  logic [4:0]         ofill_r, ofill_nxt;
  logic [12:0]        otot_r, otot_nxt;
  logic [ENTRY_W-1:0] oent_r, oent_nxt;

  logic               ent_rd_en, ent_wr_en;
  logic [AW-1:0]      ent_rd_addr, ent_wr_addr;
  logic [ENTRY_W-1:0] ent_wr_data, ent_q;
  fill_req_t          freq;
  logic [FW-1:0]      fill_q;
  logic [63:0]        xdist;
  logic [ID_W-1:0]    pid_cat;

  kbt_ram #(.WIDTH(ENTRY_W), .DEPTH(NSLOT)) u_entries (
    .clk     (clk),
    .wr_en   (ent_wr_en),
    .wr_addr (ent_wr_addr),
    .wr_data (ent_wr_data),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_rd_addr),
    .rd_data (ent_q)
  );

  kbt_fill #(.FW(FW)) u_fill (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (freq),
    .wr_fill (fill_r),
    .rd_fill (fill_q)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign pid_cat   = {pid_r[0], pid_r[1], pid_r[2], pid_r[3]};
  assign xdist     = local_id_r[w_r] ^ pid_r[w_r];

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pid_nxt       = pid_r;
    paddr_nxt     = paddr_r;
    ptime_nxt     = ptime_r;
    rslot_nxt     = rslot_r;
    w_nxt         = w_r;
    bkt_nxt       = bkt_r;
    bvalid_nxt    = bvalid_r;
    base_nxt      = base_r;
    fill_nxt      = fill_r;
    s_nxt         = s_r;
    total_nxt     = total_r;
    found_nxt     = found_r;
    fpend_nxt     = fpend_r;
    status_nxt    = status_r;
    ent_nxt       = ent_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ostat_nxt     = ostat_r;
    obkt_nxt      = obkt_r;
    obv_nxt       = obv_r;
    ofill_nxt     = ofill_r;
    otot_nxt      = otot_r;
    oent_nxt      = oent_r;
    ent_rd_en     = 1'b0;
    ent_rd_addr   = base_r + AW'(s_r);
    ent_wr_en     = 1'b0;
    ent_wr_addr   = base_r + AW'(s_r);
    ent_wr_data   = ent_q;
    freq.rd_en    = 1'b0;
    freq.wr_en    = 1'b0;
    freq.bkt      = bkt_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = cmd_t'(in_command);
          pid_nxt[0] = in_peer_id_w0;
          pid_nxt[1] = in_peer_id_w1;
          pid_nxt[2] = in_peer_id_w2;
          pid_nxt[3] = in_peer_id_w3;
          paddr_nxt  = in_peer_address;
          ptime_nxt  = in_now_time;
          rslot_nxt  = in_read_slot;
          ent_nxt    = '0;
          fpend_nxt  = 1'b0;
          found_nxt  = 1'b0;
          status_nxt = ST_OK;
          w_nxt      = '0;
          if (cmd_t'(in_command) == CMD_READ) begin
            bkt_nxt    = in_read_bucket;
            bvalid_nxt = 1'b1;
            state_nxt  = S_BASE;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end
      S_FIND: begin
        // one 64-bit word of the distance per cycle, most significant first
        if (xdist != '0) begin
          bkt_nxt    = {2'd3 - w_r, msb64(xdist)};
          bvalid_nxt = 1'b1;
          state_nxt  = S_BASE;
        end else if (w_r == 2'd3) begin
          bkt_nxt    = '0;
          bvalid_nxt = 1'b0;
          fill_nxt   = '0;
          status_nxt = ST_SELF;
          state_nxt  = S_FIN;
        end else begin
          w_nxt = w_r + 2'd1;
        end
      end
      S_BASE: begin
        base_nxt   = AW'(bkt_r) * SLOTS_A;
        freq.rd_en = 1'b1;
        state_nxt  = S_FILL_WAIT;
      end
      S_FILL_WAIT: begin
        fill_nxt = fill_q;
        s_nxt    = '0;
        if (cmd_r == CMD_READ) begin
          if (CW'(rslot_r) < CW'(fill_q)) begin
            ent_rd_en   = 1'b1;
            ent_rd_addr = base_r + AW'(rslot_r);
            state_nxt   = S_ENT_WAIT;
          end else begin
            status_nxt = ST_NOTFOUND;
            state_nxt  = S_FIN;
          end
        end else begin
          state_nxt = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (s_r == fill_r) begin
          found_nxt = 1'b0;
          state_nxt = S_DECIDE;
        end else begin
          ent_rd_en = 1'b1;
          state_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (ent_q[ENTRY_W-1 -: ID_W] == pid_cat) begin
          found_nxt = 1'b1;
          state_nxt = S_DECIDE;
        end else begin
          s_nxt     = s_r + FW'(1);
          state_nxt = S_SRCH_RD;
        end
      end
      S_DECIDE: begin
        state_nxt = S_FIN;
        case (cmd_r)
          CMD_INSERT: begin
            if (!found_r && fill_r >= SLOTS_F) begin
              status_nxt = ST_FULL;
            end else begin
              if (!found_r) begin
                s_nxt     = fill_r;
                fill_nxt  = fill_r + FW'(1);
                total_nxt = total_r + TW'(1);
                fpend_nxt = 1'b1;
              end
              // s_r equals fill_r when not found
              state_nxt = (s_r == '0) ? S_WR_NEW : S_SH_RD;
            end
          end
          CMD_REMOVE: begin
            if (!found_r) begin
              status_nxt = ST_NOTFOUND;
            end else begin
              fill_nxt  = fill_r - FW'(1);
              total_nxt = total_r - TW'(1);
              fpend_nxt = 1'b1;
              if (CW'(s_r) + CW'(1) < CW'(fill_r)) begin
                state_nxt = S_SH_RD;
              end
            end
          end
          default: ;
        endcase
      end
      S_SH_RD: begin
        ent_rd_en   = 1'b1;
        ent_rd_addr = (cmd_r == CMD_INSERT) ? base_r + AW'(s_r) - AW'(1)
                                            : base_r + AW'(s_r) + AW'(1);
        state_nxt   = S_SH_WR;
      end
      S_SH_WR: begin
        ent_wr_en = 1'b1;
        if (cmd_r == CMD_INSERT) begin
          s_nxt     = s_r - FW'(1);
          state_nxt = (s_r == FW'(1)) ? S_WR_NEW : S_SH_RD;
        end else begin
          s_nxt     = s_r + FW'(1);
          state_nxt = (CW'(s_r) + CW'(2) < CW'(fill_r) + CW'(1)) ? S_SH_RD : S_FIN;
        end
      end
      S_WR_NEW: begin
        ent_wr_en   = 1'b1;
        ent_wr_addr = base_r;
        ent_wr_data = {pid_cat, paddr_r, ptime_r};
        state_nxt   = S_FIN;
      end
      S_ENT_WAIT: begin
        ent_nxt   = ent_q;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        freq.wr_en = fpend_r;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          ostat_nxt     = status_r;
          obkt_nxt      = bkt_r;
          obv_nxt       = bvalid_r;
          ofill_nxt     = 5'(fill_r);
          otot_nxt      = 13'(total_r);
          oent_nxt      = ent_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      fpend_r     <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        local_id_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      fpend_r     <= fpend_nxt;
      if (cfg_valid) begin
        local_id_r[cfg_index] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    pid_r    <= pid_nxt;
    paddr_r  <= paddr_nxt;
    ptime_r  <= ptime_nxt;
    rslot_r  <= rslot_nxt;
    w_r      <= w_nxt;
    bkt_r    <= bkt_nxt;
    bvalid_r <= bvalid_nxt;
    base_r   <= base_nxt;
    fill_r   <= fill_nxt;
    s_r      <= s_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    ent_r    <= ent_nxt;
    ostat_r  <= ostat_nxt;
    obkt_r   <= obkt_nxt;
    obv_r    <= obv_nxt;
    ofill_r  <= ofill_nxt;
    otot_r   <= otot_nxt;
    oent_r   <= oent_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = ostat_r;
  assign out_bucket_number   = obkt_r;
  assign out_bucket_valid    = obv_r;
  assign out_bucket_fill     = ofill_r;
  assign out_table_total     = otot_r;
  assign out_entry_id_w0     = oent_r[ENTRY_W-1 -: 64];
  assign out_entry_id_w1     = oent_r[ENTRY_W-65 -: 64];
  assign out_entry_id_w2     = oent_r[ENTRY_W-129 -: 64];
  assign out_entry_id_w3     = oent_r[ENTRY_W-193 -: 64];
  assign out_entry_address   = oent_r[127:64];
  assign out_entry_last_seen = oent_r[63:0];

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= NSLOT_T)
    else $error("table total above capacity");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |-> fill_r <= SLOTS_F)
    else $error("bucket fill above capacity");

  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ostat_r == ST_FULL |-> ofill_r == 5'(BUCKET_SLOTS))
    else $error("full status with bucket not full");

  a_self_inval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ostat_r == ST_SELF |-> !obv_r && obkt_r == '0)
    else $error("self status with valid bucket");

endmodule
`default_nettype wire
